/* rtl/core/lfi_pkg.sv */
// ---------------------------------------------------------------------------
// lfi_pkg
// Shared types and constants for the link fault injector.
// ---------------------------------------------------------------------------
package lfi_pkg;

  localparam int unsigned MaxDurationUnits = 600;
  localparam logic [31:0] TicksPerUnitReset = 32'd10000000;

  typedef enum logic [2:0] {
    REQ_SET   = 3'd0,
    REQ_CLEAR = 3'd1,
    REQ_TICK  = 3'd2,
    REQ_QUERY = 3'd3,
    REQ_TAKE  = 3'd4,
    REQ_READ  = 3'd5
  } req_t;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_DROP   = 2'd1;
  localparam logic [1:0] MODE_BYPASS = 2'd2;
  localparam logic [1:0] DIR_BOTH    = 2'd0;
  localparam logic [1:0] DIR_FWD     = 2'd1;
  localparam logic [1:0] DIR_REV     = 2'd2;

  localparam logic [3:0] ST_APPLIED  = 4'd0;
  localparam logic [3:0] ST_REJECTED = 4'd1;
  localparam logic [3:0] ST_REASON   = 4'd2;
  localparam logic [3:0] ST_DUP      = 4'd3;
  localparam logic [3:0] ST_CLEARS   = 4'd4;
  localparam logic [3:0] ST_TIMEOUTS = 4'd5;
  localparam logic [3:0] ST_DROPPED  = 4'd6;
  localparam logic [3:0] ST_FWD      = 4'd7;
  localparam logic [3:0] ST_REV      = 4'd8;
  localparam logic [3:0] ST_DUR_MS   = 4'd9;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  fault_mode;
    logic [1:0]  direction;
    logic [9:0]  duration_units;
    logic [1:0]  bridge_mode;
    logic [31:0] timer_now;
    logic        take_select;
    logic [3:0]  stat_index;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic        fault_active;
    logic        bypass_active;
    logic        owns_selector;
    logic [9:0]  units_left;
    logic [31:0] stat_value;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_TICK, S_MUL, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

/* rtl/core/lfi_divider.sv */
// ---------------------------------------------------------------------------
// lfi_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lfi_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  lfi_pkg::div_req_t req,
  output lfi_pkg::div_rsp_t rsp
);
  import lfi_pkg::*;

  logic [31:0] quot_r, quot_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quot_r[31]} - {1'b0, dvs_r};
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt  = trial[31:0];
        quot_nxt = {quot_r[30:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[30:0], quot_r[31]};
        quot_nxt = {quot_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;
endmodule

/* rtl/core/link_fault_injector_unit.sv */
// ---------------------------------------------------------------------------
// link_fault_injector_unit
// Fault injector for a two-way byte bridge: set, clear, tick, query, take, stats.
// ---------------------------------------------------------------------------
// channel | direction | handshake     | payload
// in_     | input     | valid / stall | lfi_pkg::in_word_t
// out_    | output    | valid / stall | lfi_pkg::out_word_t
// cfg_    | input     | valid / ready | ticks_per_unit, 32 bits
//
// A tick that counts down runs through S_DIV, S_TICK (waiting for the 32-step
// divider) and S_OUT; a read of duration_ms passes through the multiply step
// S_MUL, others go from S_DIV to S_OUT. The next word is taken back in S_IDLE.
// Synchronous active-low reset clears control state and counters and loads tpu_r.
// in_stall is high while a word is in work; a stalled result holds the last step.
module link_fault_injector_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lfi_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lfi_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import lfi_pkg::*;

  state_t      state_r, state_nxt;
  in_word_t    req_r, req_nxt;
  out_word_t   res_r, res_nxt;
  out_word_t   wrk_r, wrk_nxt;
  logic [31:0] tpu_r;
  logic        act_r, act_nxt;
  logic [1:0]  mode_r, mode_nxt, dir_r, dir_nxt, bm_r, bm_nxt;
  logic [9:0]  sdur_r, sdur_nxt, rem_r, rem_nxt;
  logic [31:0] last_r, last_nxt, part_r, part_nxt;
  logic        bexp_r, bexp_nxt, sexp_r, sexp_nxt;
  logic [25:0] reason_r, reason_nxt;
  logic [31:0] cnt_r [8];
  logic [31:0] cnt_nxt [8];
  logic [31:0] mul_r, mul_nxt;
  logic        out_valid_r, out_valid_nxt;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        bad, dup, byp;
  logic [32:0] psum;
  logic [32:0] elapsed;

  lfi_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r; req_nxt = req_r; res_nxt = res_r; wrk_nxt = wrk_r;
    act_nxt = act_r; mode_nxt = mode_r; dir_nxt = dir_r; bm_nxt = bm_r;
    sdur_nxt = sdur_r; rem_nxt = rem_r; last_nxt = last_r; part_nxt = part_r;
    bexp_nxt = bexp_r; sexp_nxt = sexp_r; reason_nxt = reason_r;
    for (int i = 0; i < 8; i++) cnt_nxt[i] = cnt_r[i];
    mul_nxt = mul_r;
    out_valid_nxt = out_valid_r && out_stall;
    dreq = '0;
    dreq.dividend = req_r.timer_now - last_r;
    dreq.divisor  = tpu_r;
    bad = !(req_r.fault_mode == MODE_DROP || req_r.fault_mode == MODE_BYPASS) ||
          req_r.direction > DIR_REV || {22'd0, req_r.duration_units} > MaxDurationUnits ||
          req_r.bridge_mode > 2'd2;
    dup = act_r && mode_r == req_r.fault_mode && dir_r == req_r.direction &&
          bm_r == req_r.bridge_mode && sdur_r == req_r.duration_units;
    psum = {1'b0, part_r} + {1'b0, drsp.rem};
    elapsed = {1'b0, drsp.quot};
    byp = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        wrk_nxt = '0;
        state_nxt = S_OUT;
        case (req_r.req_type)
          REQ_SET: begin
            if (bad) begin
              cnt_nxt[1] = cnt_r[1] + 32'd1;
              reason_nxt = {8'd0, req_r.fault_mode, 16'd0} |
                           {16'd0, req_r.direction, 8'd0} | {16'd0, req_r.duration_units};
            end else begin
              wrk_nxt.ok = 1'b1;
              cnt_nxt[0] = cnt_r[0] + 32'd1;
              if (dup) cnt_nxt[2] = cnt_r[2] + 32'd1;
              else begin
                mode_nxt = req_r.fault_mode; dir_nxt = req_r.direction;
                bm_nxt = req_r.bridge_mode; sdur_nxt = req_r.duration_units;
                rem_nxt = req_r.duration_units; last_nxt = req_r.timer_now;
                part_nxt = '0; bexp_nxt = 1'b0; sexp_nxt = 1'b0; act_nxt = 1'b1;
              end
            end
          end
          REQ_CLEAR: begin
            act_nxt = 1'b0; mode_nxt = MODE_OFF; dir_nxt = DIR_BOTH; bm_nxt = '0;
            rem_nxt = '0; sdur_nxt = '0; last_nxt = req_r.timer_now; part_nxt = '0;
            cnt_nxt[3] = cnt_r[3] + 32'd1;
          end
          REQ_TICK: begin
            if (act_r && sdur_r != '0 && tpu_r != '0) begin
              dreq.start = 1'b1;
              state_nxt = S_TICK;
            end
          end
          REQ_QUERY: begin
            if (act_r && mode_r == MODE_DROP &&
                (dir_r == DIR_BOTH || dir_r == req_r.direction)) begin
              wrk_nxt.ok = 1'b1;
              cnt_nxt[5] = cnt_r[5] + 32'd1;
              if (req_r.direction == DIR_FWD) cnt_nxt[6] = cnt_r[6] + 32'd1;
              else cnt_nxt[7] = cnt_r[7] + 32'd1;
            end
          end
          REQ_TAKE: begin
            if (!req_r.take_select) begin
              wrk_nxt.ok = bexp_r; bexp_nxt = 1'b0;
            end else begin
              wrk_nxt.ok = sexp_r; sexp_nxt = 1'b0;
            end
          end
          REQ_READ: begin
            case (req_r.stat_index)
              ST_APPLIED:  wrk_nxt.stat_value = cnt_r[0];
              ST_REJECTED: wrk_nxt.stat_value = cnt_r[1];
              ST_REASON:   wrk_nxt.stat_value = {6'd0, reason_r};
              ST_DUP:      wrk_nxt.stat_value = cnt_r[2];
              ST_CLEARS:   wrk_nxt.stat_value = cnt_r[3];
              ST_TIMEOUTS: wrk_nxt.stat_value = cnt_r[4];
              ST_DROPPED:  wrk_nxt.stat_value = cnt_r[5];
              ST_FWD:      wrk_nxt.stat_value = cnt_r[6];
              ST_REV:      wrk_nxt.stat_value = cnt_r[7];
              ST_DUR_MS: begin
                mul_nxt = {22'd0, sdur_r} * 32'd100;
                state_nxt = S_MUL;
              end
              default:     wrk_nxt.stat_value = '0;
            endcase
          end
          default: ;
        endcase
      end
      S_MUL: begin
        wrk_nxt.stat_value = mul_r;
        state_nxt = S_OUT;
      end
      S_TICK: begin
        if (drsp.done) begin
          last_nxt = req_r.timer_now;
          if (psum >= {1'b0, tpu_r}) begin
            elapsed = elapsed + 33'd1;
            part_nxt = 32'(psum - {1'b0, tpu_r});
          end else part_nxt = psum[31:0];
          if ({23'd0, rem_r} > elapsed) rem_nxt = rem_r - elapsed[9:0];
          else rem_nxt = '0;
          if (rem_nxt == '0) begin
            cnt_nxt[4] = cnt_r[4] + 32'd1;
            cnt_nxt[3] = cnt_r[3] + 32'd1;
            act_nxt = 1'b0; mode_nxt = MODE_OFF; dir_nxt = DIR_BOTH; bm_nxt = '0;
            sdur_nxt = '0; part_nxt = '0;
            if (mode_r == MODE_BYPASS) begin
              bexp_nxt = 1'b1;
              sexp_nxt = (bm_r == 2'd0);
            end
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          byp = act_r && mode_r == MODE_BYPASS;
          res_nxt = wrk_r;
          res_nxt.fault_active = act_r;
          res_nxt.bypass_active = byp;
          res_nxt.owns_selector = byp && bm_r == 2'd0;
          res_nxt.units_left = rem_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0; tpu_r <= TicksPerUnitReset;
      act_r <= 1'b0; mode_r <= MODE_OFF; dir_r <= DIR_BOTH; bm_r <= '0;
      sdur_r <= '0; rem_r <= '0; last_r <= '0; part_r <= '0;
      bexp_r <= 1'b0; sexp_r <= 1'b0; reason_r <= '0;
      for (int i = 0; i < 8; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
      if (cfg_valid) tpu_r <= cfg_data;
      act_r <= act_nxt; mode_r <= mode_nxt; dir_r <= dir_nxt; bm_r <= bm_nxt;
      sdur_r <= sdur_nxt; rem_r <= rem_nxt; last_r <= last_nxt; part_r <= part_nxt;
      bexp_r <= bexp_nxt; sexp_r <= sexp_nxt; reason_r <= reason_nxt;
      for (int i = 0; i < 8; i++) cnt_r[i] <= cnt_nxt[i];
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    wrk_r <= wrk_nxt;
    mul_r <= mul_nxt;
  end

  a_idle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DIV))
    else $error("accepted word did not start processing");
  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !act_r |-> (rem_r == '0))
    else $error("units left while inactive");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
endmodule
